// ===== hdl/pit_pkg.sv =====
`default_nettype none

package pit_pkg;

    localparam int COUNT_WIDTH    = 32;
    localparam int PRESCALE_WIDTH = 12;
    localparam int BUS_WIDTH      = 32;

    // control register bit positions
    localparam int EN        = 0;
    localparam int ENMOD     = 1;
    localparam int OCIEN     = 2;
    localparam int RLD       = 3;
    localparam int PRESCALER = 4;
    localparam int IOVW      = 17;
    localparam int CLKSRC    = 24;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_CONTROL = 3'd0,
        REG_STATUS  = 3'd1,
        REG_LOAD    = 3'd2,
        REG_COMPARE = 3'd3,
        REG_COUNTER = 3'd4
    } reg_sel_t;

    typedef enum logic [1:0] {
        CLK_OFF = 2'd0,
        CLK_IPG = 2'd1,
        CLK_HF  = 2'd2,
        CLK_32K = 2'd3
    } clk_src_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
        logic [2:0]  clock_ticks;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        compare_event;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/periodic_interrupt_timer.sv =====
// Down-counting periodic interrupt timer, driven one transaction at a time.
// Input channel (item_valid / item_stall / item): each transaction is a
// clock tick (with a mask of which clock sources ticked), a register write
// or a register read. Output channel (result_valid / result_stall / result):
// exactly one result per input transaction, in order, carrying read data
// (zero unless a read), the irq line and a compare-event pulse.
// An accepted transaction is held in the input register, then makes one pass
// through the timer logic into the result register.
// Throughput: one transaction per cycle while result_stall is low, set by the
// single-pass update of the timer state between the two registers.
// Reset: asynchronous, active low; the timer returns to its documented
// reset state (disabled, peripheral clock selected, counter and load all
// ones) and both pipeline registers empty.
// Stall: when result_stall holds a pending result, the held transaction
// waits in the input register and item_stall rises; state is only
// updated when the transaction moves into the result register.
`default_nettype none

module periodic_interrupt_timer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire pit_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output pit_pkg::result_t       result
);
    import pit_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t core_result;
    logic    advance;

    // held transaction moves on when the result slot is free or draining
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;

    pit_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!item_stall)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== hdl/pit_core.sv =====
`default_nettype none

// Timer state and the per-transaction next-state / result logic.
module pit_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire pit_pkg::item_t  item,
    output pit_pkg::result_t     result
);
    import pit_pkg::*;

    logic                      enable_reg, enable_next;
    logic                      restart_mode_reg, restart_mode_next;
    logic                      irq_enable_reg, irq_enable_next;
    logic                      reload_mode_reg, reload_mode_next;
    logic [PRESCALE_WIDTH-1:0] prescale_setting_reg, prescale_setting_next;
    logic                      load_overwrite_reg, load_overwrite_next;
    logic [1:0]                clock_select_reg, clock_select_next;
    logic [COUNT_WIDTH-1:0]    reload_value_reg, reload_value_next;
    logic [COUNT_WIDTH-1:0]    compare_value_reg, compare_value_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [PRESCALE_WIDTH-1:0] prescale_count_reg, prescale_count_next;
    logic                      status_flag_reg, status_flag_next;

    logic                      src_tick;
    logic                      event_flag;
    logic [COUNT_WIDTH-1:0]    restart_value;
    logic [COUNT_WIDTH-1:0]    wdata_cnt;
    logic [BUS_WIDTH-1:0]      control_word;
    logic [BUS_WIDTH-1:0]      rd;

    assign restart_value = reload_mode_reg ? reload_value_reg : '1;
    assign wdata_cnt     = item.write_data[COUNT_WIDTH-1:0];

    // selected tick source
    always_comb
    begin
        case (clock_select_reg)
            CLK_IPG: src_tick = item.clock_ticks[0];
            CLK_HF:  src_tick = item.clock_ticks[1];
            CLK_32K: src_tick = item.clock_ticks[2];
            default: src_tick = 1'b0;
        endcase
    end

    always_comb
    begin
        control_word = '0;
        control_word[EN]    = enable_reg;
        control_word[ENMOD] = restart_mode_reg;
        control_word[OCIEN] = irq_enable_reg;
        control_word[RLD]   = reload_mode_reg;
        control_word[PRESCALER +: PRESCALE_WIDTH] = prescale_setting_reg;
        control_word[IOVW]  = load_overwrite_reg;
        control_word[CLKSRC +: 2] = clock_select_reg;
    end

    always_comb
    begin
        enable_next           = enable_reg;
        restart_mode_next     = restart_mode_reg;
        irq_enable_next       = irq_enable_reg;
        reload_mode_next      = reload_mode_reg;
        prescale_setting_next = prescale_setting_reg;
        load_overwrite_next   = load_overwrite_reg;
        clock_select_next     = clock_select_reg;
        reload_value_next     = reload_value_reg;
        compare_value_next    = compare_value_reg;
        count_next            = count_reg;
        prescale_count_next   = prescale_count_reg;
        status_flag_next      = status_flag_reg;
        event_flag            = 1'b0;
        rd                    = '0;

        case (item.action)
            ACT_TICK:
            begin
                if (enable_reg && src_tick) begin
                    if (prescale_count_reg < prescale_setting_reg) begin
                        prescale_count_next = prescale_count_reg + 1'b1;
                    end else begin
                        prescale_count_next = '0;
                        if (count_reg == '0)
                            count_next = restart_value;
                        else
                            count_next = count_reg - 1'b1;
                        if (count_next == compare_value_reg) begin
                            status_flag_next = 1'b1;
                            event_flag       = 1'b1;
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                case (item.reg_select)
                    REG_CONTROL:
                    begin
                        enable_next           = item.write_data[EN];
                        restart_mode_next     = item.write_data[ENMOD];
                        irq_enable_next       = item.write_data[OCIEN];
                        reload_mode_next      = item.write_data[RLD];
                        prescale_setting_next =
                            item.write_data[PRESCALER +: PRESCALE_WIDTH];
                        load_overwrite_next   = item.write_data[IOVW];
                        clock_select_next     = item.write_data[CLKSRC +: 2];
                        // rising enable with restart mode: restart from reload value, or all ones
                        if (!enable_reg && item.write_data[EN] &&
                            item.write_data[ENMOD]) begin
                            count_next = item.write_data[RLD] ? reload_value_reg : '1;
                            prescale_count_next = '0;
                        end
                    end
                    REG_STATUS:
                    begin
                        if (item.write_data[0])
                            status_flag_next = 1'b0;
                    end
                    REG_LOAD:
                    begin
                        reload_value_next = wdata_cnt;
                        if (load_overwrite_reg)
                            count_next = wdata_cnt;
                    end
                    REG_COMPARE: compare_value_next = wdata_cnt;
                    default: ;
                endcase
            end
            ACT_READ:
            begin
                case (item.reg_select)
                    REG_CONTROL: rd = control_word;
                    REG_STATUS:  rd = BUS_WIDTH'(status_flag_reg);
                    REG_LOAD:    rd = BUS_WIDTH'(reload_value_reg);
                    REG_COMPARE: rd = BUS_WIDTH'(compare_value_reg);
                    REG_COUNTER: rd = BUS_WIDTH'(count_reg);
                    default:     rd = '0;
                endcase
            end
            default: ;
        endcase
    end

    assign result.read_data     = rd;
    assign result.irq           = status_flag_next & irq_enable_next;
    assign result.compare_event = event_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg           <= 1'b0;
            restart_mode_reg     <= 1'b0;
            irq_enable_reg       <= 1'b0;
            reload_mode_reg      <= 1'b0;
            prescale_setting_reg <= '0;
            load_overwrite_reg   <= 1'b0;
            clock_select_reg     <= CLK_IPG;
            reload_value_reg     <= '1;
            compare_value_reg    <= '0;
            count_reg            <= '1;
            prescale_count_reg   <= '0;
            status_flag_reg      <= 1'b0;
        end else if (fire) begin
            enable_reg           <= enable_next;
            restart_mode_reg     <= restart_mode_next;
            irq_enable_reg       <= irq_enable_next;
            reload_mode_reg      <= reload_mode_next;
            prescale_setting_reg <= prescale_setting_next;
            load_overwrite_reg   <= load_overwrite_next;
            clock_select_reg     <= clock_select_next;
            reload_value_reg     <= reload_value_next;
            compare_value_reg    <= compare_value_next;
            count_reg            <= count_next;
            prescale_count_reg   <= prescale_count_next;
            status_flag_reg      <= status_flag_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/periodic_interrupt_timer_checker.sv =====
module periodic_interrupt_timer_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire pit_pkg::item_t    item,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire pit_pkg::result_t  result,
    output int unsigned            fail_count,
    output int unsigned            open_count,
    output int unsigned            checked_count,
    output int unsigned            hit_count,
    output int unsigned            irq_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    // shadow copy of the timer registers
    logic                      tm_enable;
    logic                      tm_restart;
    logic                      tm_irq_en;
    logic                      tm_reload;
    logic [PRESCALE_WIDTH-1:0] tm_presc_set;
    logic                      tm_overwrite;
    logic [1:0]                tm_clk_sel;
    logic [COUNT_WIDTH-1:0]    tm_load;
    logic [COUNT_WIDTH-1:0]    tm_compare;
    logic [COUNT_WIDTH-1:0]    tm_count;
    logic [PRESCALE_WIDTH-1:0] tm_presc_cnt;
    logic                      tm_status;

    result_t     awaited_results[$];
    result_t     predicted;
    result_t     oldest;
    int unsigned fails;
    int unsigned checked;
    int unsigned hits;
    int unsigned irqs;

    // advance the shadow timer by one transaction and form its result
    task automatic apply_item(input item_t it, output result_t res);
        logic [BUS_WIDTH-1:0] rd;
        logic                 hit;
        logic                 was_on;
        rd     = '0;
        hit    = 1'b0;
        was_on = tm_enable;
        case (it.action)
            ACT_TICK: begin
                if (tm_enable && tm_clk_sel != CLK_OFF
                    && it.clock_ticks[tm_clk_sel - 2'd1]) begin
                    if (tm_presc_cnt < tm_presc_set) begin
                        tm_presc_cnt = tm_presc_cnt + 1'b1;
                    end
                    else begin
                        tm_presc_cnt = '0;
                        if (tm_count == '0)
                            tm_count = tm_reload ? tm_load : '1;
                        else
                            tm_count = tm_count - 1'b1;
                        if (tm_count == tm_compare) begin
                            tm_status = 1'b1;
                            hit       = 1'b1;
                        end
                    end
                end
            end
            ACT_WRITE: begin
                case (it.reg_select)
                    REG_CONTROL: begin
                        tm_enable    = it.write_data[EN];
                        tm_restart   = it.write_data[ENMOD];
                        tm_irq_en    = it.write_data[OCIEN];
                        tm_reload    = it.write_data[RLD];
                        tm_presc_set = it.write_data[PRESCALER +: PRESCALE_WIDTH];
                        tm_overwrite = it.write_data[IOVW];
                        tm_clk_sel   = it.write_data[CLKSRC +: 2];
                        if (!was_on && tm_enable && tm_restart) begin
                            tm_count     = tm_reload ? tm_load : '1;
                            tm_presc_cnt = '0;
                        end
                    end
                    REG_STATUS: begin
                        if (it.write_data[0])
                            tm_status = 1'b0;
                    end
                    REG_LOAD: begin
                        tm_load = it.write_data[COUNT_WIDTH-1:0];
                        if (tm_overwrite)
                            tm_count = tm_load;
                    end
                    REG_COMPARE: tm_compare = it.write_data[COUNT_WIDTH-1:0];
                    default: ;
                endcase
            end
            ACT_READ: begin
                case (it.reg_select)
                    REG_CONTROL: begin
                        rd[EN]                            = tm_enable;
                        rd[ENMOD]                         = tm_restart;
                        rd[OCIEN]                         = tm_irq_en;
                        rd[RLD]                           = tm_reload;
                        rd[PRESCALER +: PRESCALE_WIDTH]   = tm_presc_set;
                        rd[IOVW]                          = tm_overwrite;
                        rd[CLKSRC +: 2]                   = tm_clk_sel;
                    end
                    REG_STATUS:  rd[0] = tm_status;
                    REG_LOAD:    rd[COUNT_WIDTH-1:0] = tm_load;
                    REG_COMPARE: rd[COUNT_WIDTH-1:0] = tm_compare;
                    REG_COUNTER: rd[COUNT_WIDTH-1:0] = tm_count;
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.read_data     = rd;
        res.irq           = tm_status & tm_irq_en;
        res.compare_event = hit;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tm_enable    = 1'b0;
            tm_restart   = 1'b0;
            tm_irq_en    = 1'b0;
            tm_reload    = 1'b0;
            tm_presc_set = '0;
            tm_overwrite = 1'b0;
            tm_clk_sel   = CLK_IPG;
            tm_load      = '1;
            tm_compare   = '0;
            tm_count     = '1;
            tm_presc_cnt = '0;
            tm_status    = 1'b0;
            awaited_results.delete();
            fails   = 0;
            checked = 0;
            hits    = 0;
            irqs    = 0;
        end
        else begin
            // retire first so a stray result never matches this cycle's push
            if (result_valid && !result_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %h",
                             $time, result);
                    fails++;
                end
                else begin
                    oldest = awaited_results.pop_front();
                    checked++;
                    if (result.compare_event === 1'b1)
                        hits++;
                    if (result.irq === 1'b1)
                        irqs++;
                    if (result.read_data !== oldest.read_data) begin
                        $display("%0t ns: read_data expected %h, got %h",
                                 $time, oldest.read_data, result.read_data);
                        fails++;
                    end
                    if (result.irq !== oldest.irq) begin
                        $display("%0t ns: irq expected %b, got %b",
                                 $time, oldest.irq, result.irq);
                        fails++;
                    end
                    if (result.compare_event !== oldest.compare_event) begin
                        $display("%0t ns: compare_event expected %b, got %b",
                                 $time, oldest.compare_event, result.compare_event);
                        fails++;
                    end
                end
            end
            if (item_valid && !item_stall) begin
                apply_item(item, predicted);
                awaited_results.push_back(predicted);
            end
        end
        fail_count    <= fails;
        open_count    <= awaited_results.size();
        checked_count <= checked;
        hit_count     <= hits;
        irq_count     <= irqs;
    end

endmodule

// ===== verif/periodic_interrupt_timer_test.sv =====
module periodic_interrupt_timer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int MAX_IDLE     = 13;
    localparam int MODE_SPAN    = 64;      // items between changes of idle pattern
    localparam int DRAIN_CYCLES = 8;       // margin after the last result drains
    // ~1300 transactions, each held up at worst by a full idle draw, a full stall
    // draw and the pipeline, stay well under this limit
    localparam int CYCLE_LIMIT  = 200000;

    // register numbers with no register behind them
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    // clock_ticks mask bits
    localparam logic [2:0] TICK_IPG = 3'b001;
    localparam logic [2:0] TICK_HF  = 3'b010;
    localparam logic [2:0] TICK_32K = 3'b100;
    localparam logic [2:0] TICK_ALL = 3'b111;

    // idle patterns: none at all, full range, or occasional
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_FULL   = 1;
    localparam int IDLE_SPARSE = 2;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int unsigned fail_count;
    int unsigned open_count;
    int unsigned checked_count;
    int unsigned hit_count;
    int unsigned irq_count;
    int unsigned cycle_count = 0;

    int send_mode  = IDLE_FULL;
    int stall_mode = IDLE_FULL;
    int stall_left = 0;
    int stall_draw;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    periodic_interrupt_timer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    periodic_interrupt_timer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .checked_count (checked_count),
        .hit_count     (hit_count),
        .irq_count     (irq_count)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_idle(input int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, MAX_IDLE);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_IDLE) : 0;
        endcase
    endfunction

    // result side: after each accepted result hold stall for a drawn number
    // of cycles, so back pressure lands on every phase of the pipeline
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (result_stall) begin
            result_stall <= 1'b0;
        end
        else if (result_valid) begin
            stall_draw = draw_idle(stall_mode);
            if (stall_draw > 0) begin
                result_stall <= 1'b1;
                stall_left   <= stall_draw - 1;
            end
        end
    end

    function automatic item_t make_item(input action_t act, input logic [2:0] sel,
                                        input logic [31:0] data, input logic [2:0] ticks);
        item_t x;
        x.action      = act;
        x.reg_select  = sel;
        x.write_data  = data;
        x.clock_ticks = ticks;
        return x;
    endfunction

    function automatic logic [31:0] ctrl_word(input logic en, input logic restart,
                                              input logic irq_en, input logic reload,
                                              input logic [PRESCALE_WIDTH-1:0] presc,
                                              input logic ovw, input clk_src_t src);
        logic [31:0] w;
        w                               = '0;
        w[EN]                           = en;
        w[ENMOD]                        = restart;
        w[OCIEN]                        = irq_en;
        w[RLD]                          = reload;
        w[PRESCALER +: PRESCALE_WIDTH]  = presc;
        w[IOVW]                         = ovw;
        w[CLKSRC +: 2]                  = src;
        return w;
    endfunction

    // Random mix: mostly ticks so the counter actually moves, with load and
    // compare values kept small most of the time so compare hits and
    // reloads happen often. Full 32-bit values still appear on every field.
    function automatic item_t random_item();
        int unsigned pick;
        item_t       x;
        logic [PRESCALE_WIDTH-1:0] presc;
        pick = $urandom_range(0, 99);
        x.action      = ACT_TICK;
        x.reg_select  = 3'($urandom_range(0, 7));
        x.write_data  = $urandom();
        x.clock_ticks = 3'($urandom_range(0, 7));
        if (pick < 55) begin
            // tick transaction, random source mask
        end
        else if (pick < 63) begin
            x.action     = ACT_WRITE;
            x.reg_select = REG_CONTROL;
            if ($urandom_range(0, 5) != 0) begin
                presc = ($urandom_range(0, 9) == 0) ? PRESCALE_WIDTH'($urandom())
                                                    : PRESCALE_WIDTH'($urandom_range(0, 3));
                x.write_data = ctrl_word($urandom_range(0, 6) != 0, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), $urandom_range(0, 9) < 7,
                                         presc, 1'($urandom_range(0, 1)),
                                         clk_src_t'($urandom_range(0, 3)));
            end
        end
        else if (pick < 71) begin
            x.action     = ACT_WRITE;
            x.reg_select = REG_LOAD;
            if ($urandom_range(0, 4) != 0)
                x.write_data = $urandom_range(0, 20);
        end
        else if (pick < 77) begin
            x.action     = ACT_WRITE;
            x.reg_select = REG_COMPARE;
            if ($urandom_range(0, 4) != 0)
                x.write_data = $urandom_range(0, 20);
        end
        else if (pick < 81) begin
            x.action     = ACT_WRITE;
            x.reg_select = REG_STATUS;
        end
        else if (pick < 84) begin
            // counter and unmapped registers: writes go nowhere
            x.action     = ACT_WRITE;
            x.reg_select = 3'($urandom_range(REG_COUNTER, REG_UNUSED_HI));
        end
        else if (pick < 97) begin
            x.action = ACT_READ;
        end
        else begin
            x.action = ACT_NOP;
        end
        return x;
    endfunction

    // One input transaction. Valid only drops when a gap is drawn, so a
    // back-to-back transaction keeps valid high with a single assignment.
    task automatic send_item(input item_t x);
        int gap;
        gap = draw_idle(send_mode);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, idle action, unmapped read
        send_item(make_item(ACT_READ, REG_CONTROL, '0, '0));
        send_item(make_item(ACT_READ, REG_COUNTER, '0, '0));
        send_item(make_item(ACT_NOP, REG_UNUSED_HI, '1, TICK_ALL));
        send_item(make_item(ACT_READ, REG_UNUSED_HI, '1, '0));

        // free-running from all ones down to a compare near the top
        send_item(make_item(ACT_WRITE, REG_COMPARE, 32'hFFFF_FFFD, '0));
        send_item(make_item(ACT_WRITE, REG_CONTROL,
                            ctrl_word(1'b1, 1'b0, 1'b1, 1'b0, '0, 1'b0, CLK_IPG), '0));
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_IPG));
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_HF | TICK_32K));  // wrong source
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_IPG));            // compare hit

        // status: only bit 0 clears; counter and unmapped writes ignored
        send_item(make_item(ACT_WRITE, REG_STATUS, 32'hFFFF_FFFE, '0));
        send_item(make_item(ACT_WRITE, REG_STATUS, 32'h0000_0001, '0));
        send_item(make_item(ACT_WRITE, REG_COUNTER, '0, '0));
        send_item(make_item(ACT_WRITE, REG_UNUSED_LO, '1, '0));

        // load overwrite, reload mode: count 2 -> 1 -> 0 (hit) -> reload
        send_item(make_item(ACT_WRITE, REG_CONTROL,
                            ctrl_word(1'b1, 1'b1, 1'b1, 1'b1, '0, 1'b1, CLK_IPG), '0));
        send_item(make_item(ACT_WRITE, REG_LOAD, 32'd2, '0));
        send_item(make_item(ACT_WRITE, REG_COMPARE, '0, '0));
        repeat (3) send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_ALL));

        // disabled timer freezes; re-enable with restart mode reloads
        send_item(make_item(ACT_WRITE, REG_CONTROL,
                            ctrl_word(1'b0, 1'b1, 1'b1, 1'b1, '0, 1'b1, CLK_IPG), '0));
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_ALL));
        send_item(make_item(ACT_WRITE, REG_CONTROL,
                            ctrl_word(1'b1, 1'b1, 1'b1, 1'b1, '0, 1'b1, CLK_OFF), '0));
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_ALL));            // source off

        // prescaler count left above a newly lowered setting
        send_item(make_item(ACT_WRITE, REG_CONTROL,
                            ctrl_word(1'b1, 1'b0, 1'b1, 1'b1, '1, 1'b0, CLK_32K), '0));
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_32K));
        send_item(make_item(ACT_WRITE, REG_CONTROL,
                            ctrl_word(1'b1, 1'b0, 1'b1, 1'b1, '0, 1'b0, CLK_HF), '0));
        send_item(make_item(ACT_TICK, REG_CONTROL, '0, TICK_HF));

        // every control bit set, read back with reserved bits masked
        send_item(make_item(ACT_WRITE, REG_CONTROL, '1, '0));
        send_item(make_item(ACT_READ, REG_CONTROL, '0, '0));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % MODE_SPAN == 0) begin
                send_mode  = $urandom_range(IDLE_NONE, IDLE_SPARSE);
                stall_mode <= $urandom_range(IDLE_NONE, IDLE_SPARSE);
            end
            send_item(random_item());
        end
        item_valid <= 1'b0;

        // let the checker see the last push before watching it drain
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions checked: %0d compare hits, %0d with irq high",
                 checked_count, hit_count, irq_count);
        $display("mixed ticks on all sources, register writes and reads, random idle and stall");
        if (fail_count == 0 && open_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
